### design/met_pkg.sv
// ----------------------------------------------------------------------------
// met_pkg
// Word types, register indexes and colors shared by the escape-time block.
// ----------------------------------------------------------------------------
`default_nettype none

package met_pkg;

  // integer bits (sign included) above the fraction of every real value
  localparam int FX_INT_BITS = 4;
  // signed pixel offset from the image center and its magnitude
  localparam int DELTA_W = 13;
  localparam int MAG_W = 12;
  // divisor width: covers 3 * 4096
  localparam int DEN_W = 14;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITER = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_THR = 2'd1;

  localparam logic [7:0] MAX_ITER_RST = 8'd128;
  localparam logic [7:0] LIGHT_THR_RST = 8'd25;

  localparam logic [23:0] COLOR_LIGHT = 24'hFFFFFF;
  localparam logic [23:0] COLOR_CENTER = 24'hFF0000;
  localparam logic [23:0] COLOR_NONE = 24'h000000;

  typedef struct packed {
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  iteration_count;
    logic        write_pixel;
    logic [23:0] pixel_color;
  } out_word_t;

endpackage

`default_nettype wire

### design/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time count and pixel color for one pixel of a fixed complex view.
// ----------------------------------------------------------------------------
//  channel  ports                          word
//  input    in_push / in_full              in_word  (pixel_x, pixel_y)
//  result   out_pop / out_empty            out_word (count, write, color)
//  config   cfg_we, cfg_index, cfg_data    max_iterations, light_threshold
//
//  Mapping runs a reciprocal multiply in three stages and holds while the
//  queue is full; a new pixel is taken only once the last one is pushed.
//  Iteration runs each step of the shared complex multiply-add through the
//  back end states B_MUL and B_ADD, then ends the pixel in B_FIN.
//  Mapping of the next pixel overlaps iteration of the current one.
//  Reset is synchronous, clears control and loads the config defaults; no clearing pass.
//  A result not popped holds the iterator; the queue keeps the input open.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time #(
  parameter int IMAGE_WIDTH = 1024,
  parameter int IMAGE_HEIGHT = 1024,
  parameter int FRACTION_BITS = 28,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_push,
  output logic                                 in_full,
  input  wire met_pkg::in_word_t               in_word,
  output logic                                 out_empty,
  input  wire                                  out_pop,
  output met_pkg::out_word_t                   out_word,
  input  wire                                  cfg_we,
  input  wire [met_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire [met_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int ZW = FRACTION_BITS + met_pkg::FX_INT_BITS;
  localparam int QW = 2 * ZW + 1;

  logic [7:0] max_iter_r, light_thr_r;

  logic          f_push, q_full, q_empty, q_pop;
  logic [ZW-1:0] f_re, f_im;
  logic          f_center;
  logic [QW-1:0] q_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r  <= met_pkg::MAX_ITER_RST;
      light_thr_r <= met_pkg::LIGHT_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        met_pkg::REG_MAX_ITER:  max_iter_r  <= cfg_data;
        met_pkg::REG_LIGHT_THR: light_thr_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  met_front #(
    .IMAGE_WIDTH   (IMAGE_WIDTH),
    .IMAGE_HEIGHT  (IMAGE_HEIGHT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_word (in_word),
    .q_push  (f_push),
    .q_full  (q_full),
    .c_re    (f_re),
    .c_im    (f_im),
    .center  (f_center)
  );

  met_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (QW)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   ({f_center, f_im, f_re}),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  met_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .c_re      (q_dout[ZW-1:0]),
    .c_im      (q_dout[2*ZW-1:ZW]),
    .center    (q_dout[QW-1]),
    .max_iter  (max_iter_r),
    .light_thr (light_thr_r),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

### design/met_div.sv
// ----------------------------------------------------------------------------
// met_div
// Floor division of a scaled pixel offset by a constant, by reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module met_div #(
  parameter int NUM_W = 43,
  parameter int SCALE_SH = 29,
  parameter int DENOM = 1024
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  input  wire [met_pkg::MAG_W-1:0]  mag,
  input  wire                       round_up,
  output logic                      done,
  output logic [NUM_W-1:0]          quot
);

  // quot = floor(((mag << SCALE_SH) + (round_up ? DENOM - 1 : 0)) / DENOM)
  // split as mag * Q + floor((mag * R + bias) / DENOM) with Q, R from 2^SCALE_SH;
  // the short remainder term is divided by a multiply with ceil(2^SH / DENOM)
  localparam int MW = met_pkg::MAG_W;
  localparam int DW = met_pkg::DEN_W;
  localparam int TW = MW + DW;
  localparam int MCW = TW + 1;
  localparam int PW = TW + MCW;
  localparam int QCW = SCALE_SH;
  localparam int SH = TW + $clog2(DENOM);
  localparam longint unsigned SCALE = 64'd1 << SCALE_SH;
  localparam longint unsigned DEN = 64'(DENOM);
  localparam logic [QCW-1:0] Q_C = QCW'(SCALE / DEN);
  localparam logic [DW-1:0] R_C = DW'(SCALE % DEN);
  localparam logic [DW-1:0] BIAS_C = DW'(DEN - 64'd1);
  localparam logic [MCW-1:0] M_C = MCW'(((64'd1 << SH) + DEN - 64'd1) / DEN);

  logic [3:0]        stage_r;
  logic [MW-1:0]     mag_r;
  logic              round_r;
  logic [TW-1:0]     low_r;
  logic [NUM_W-1:0]  high_r;
  logic [PW-1:0]     prod_r;
  logic [NUM_W-1:0]  quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
    end else begin
      stage_r <= {stage_r[2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r   <= mag;
      round_r <= round_up;
    end
    if (stage_r[0]) begin
      low_r  <= TW'(mag_r * R_C) + (round_r ? TW'(BIAS_C) : '0);
      high_r <= NUM_W'(mag_r * Q_C);
    end
    if (stage_r[1]) begin
      prod_r <= PW'(low_r * M_C);
    end
    if (stage_r[2]) begin
      quo_r <= high_r + NUM_W'(prod_r >> SH);
    end
  end

  assign done = stage_r[3];
  assign quot = quo_r;

endmodule

`default_nettype wire

### design/met_front.sv
// ----------------------------------------------------------------------------
// met_front
// Takes a pixel, maps it to the point c and flags the center pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module met_front #(
  parameter int IMAGE_WIDTH = 1024,
  parameter int IMAGE_HEIGHT = 1024,
  parameter int FRACTION_BITS = 28
) (
  input  wire                                          clk,
  input  wire                                          rst_n,
  input  wire                                          in_push,
  output logic                                         in_full,
  input  wire met_pkg::in_word_t                       in_word,
  output logic                                         q_push,
  input  wire                                          q_full,
  output logic [FRACTION_BITS+met_pkg::FX_INT_BITS-1:0] c_re,
  output logic [FRACTION_BITS+met_pkg::FX_INT_BITS-1:0] c_im,
  output logic                                         center
);

  localparam int ZW = FRACTION_BITS + met_pkg::FX_INT_BITS;
  localparam int NUM_W = met_pkg::MAG_W + FRACTION_BITS + 3;
  localparam int SW = NUM_W + 2;
  localparam int DTW = met_pkg::DELTA_W;
  localparam int MW = met_pkg::MAG_W;

  localparam logic signed [DTW-1:0] HALF_W = DTW'(IMAGE_WIDTH / 2);
  localparam logic signed [DTW-1:0] HALF_H = DTW'(IMAGE_HEIGHT / 2);
  localparam logic signed [SW-1:0] OFFSET_RE = SW'(3) << (FRACTION_BITS - 2);
  localparam logic signed [SW-1:0] LIM = SW'(3) << FRACTION_BITS;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic        neg_x_r, neg_y_r, center_r;

  logic                    accept;
  logic signed [DTW-1:0]   dx, dy;
  logic [DTW-1:0]          dx_neg, dy_neg;
  logic [MW-1:0]           mag_x, mag_y;
  logic                    done_x, done_y, div_done;
  logic [NUM_W-1:0]        quot_x, quot_y;
  logic signed [SW-1:0]    sq_x, sq_y, re_w, im_w, re_c, im_c;

  assign accept  = in_push && !in_full;
  assign in_full = (state_r != F_IDLE);

  always_comb begin
    dx     = $signed({3'b000, in_word.pixel_x}) - HALF_W;
    dy     = $signed({3'b000, in_word.pixel_y}) - HALF_H;
    dx_neg = -dx;
    dy_neg = -dy;
    mag_x  = dx[DTW-1] ? dx_neg[MW-1:0] : dx[MW-1:0];
    mag_y  = dy[DTW-1] ? dy_neg[MW-1:0] : dy[MW-1:0];
  end

  // floor of a negative quotient: divide |n| + d - 1 and negate
  met_div #(
    .NUM_W    (NUM_W),
    .SCALE_SH (FRACTION_BITS + 1),
    .DENOM    (IMAGE_WIDTH)
  ) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .mag      (mag_x),
    .round_up (dx[DTW-1]),
    .done     (done_x),
    .quot     (quot_x)
  );

  met_div #(
    .NUM_W    (NUM_W),
    .SCALE_SH (FRACTION_BITS + 2),
    .DENOM    (3 * IMAGE_HEIGHT)
  ) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .mag      (mag_y),
    .round_up (dy[DTW-1]),
    .done     (done_y),
    .quot     (quot_y)
  );

  assign div_done = done_x && done_y;

  always_comb begin
    sq_x = neg_x_r ? -$signed({2'b00, quot_x}) : $signed({2'b00, quot_x});
    sq_y = neg_y_r ? -$signed({2'b00, quot_y}) : $signed({2'b00, quot_y});
    re_w = sq_x - OFFSET_RE;
    im_w = sq_y;
    re_c = (re_w > LIM) ? LIM : ((re_w < -LIM) ? -LIM : re_w);
    im_c = (im_w > LIM) ? LIM : ((im_w < -LIM) ? -LIM : im_w);
  end

  assign c_re   = re_c[ZW-1:0];
  assign c_im   = im_c[ZW-1:0];
  assign center = center_r;
  assign q_push = (state_r == F_PUSH) && !q_full;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (accept) state_nxt = F_DIV;
      F_DIV:   if (div_done) state_nxt = F_PUSH;
      F_PUSH:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg_x_r  <= dx[DTW-1];
      neg_y_r  <= dy[DTW-1];
      center_r <= (dx == '0) && (dy == '0);
    end
  end

endmodule

`default_nettype wire

### design/met_fifo.sv
// ----------------------------------------------------------------------------
// met_fifo
// Short first-word-fall-through queue between the mapper and the iterator.
// ----------------------------------------------------------------------------
`default_nettype none

module met_fifo #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 65
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  wire [WIDTH-1:0]  din,
  output logic             full,
  input  wire              pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

### design/met_back.sv
// ----------------------------------------------------------------------------
// met_back
// Iterates z = z*z + c for one point and builds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module met_back #(
  parameter int FRACTION_BITS = 28
) (
  input  wire                                          clk,
  input  wire                                          rst_n,
  input  wire                                          q_empty,
  output logic                                         q_pop,
  input  wire [FRACTION_BITS+met_pkg::FX_INT_BITS-1:0] c_re,
  input  wire [FRACTION_BITS+met_pkg::FX_INT_BITS-1:0] c_im,
  input  wire                                          center,
  input  wire [7:0]                                    max_iter,
  input  wire [7:0]                                    light_thr,
  output logic                                         out_empty,
  input  wire                                          out_pop,
  output met_pkg::out_word_t                           out_word
);

  localparam int ZW = FRACTION_BITS + met_pkg::FX_INT_BITS;
  localparam int PW = 2 * ZW;

  localparam logic signed [ZW-1:0] TWO_FX = ZW'(2) << FRACTION_BITS;
  localparam logic [PW-1:0] FOUR_SQ = PW'(4) << (2 * FRACTION_BITS);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MUL  = 2'd1;
  localparam logic [1:0] B_ADD  = 2'd2;
  localparam logic [1:0] B_FIN  = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic signed [ZW-1:0]     zre_r, zim_r, cre_r, cim_r;
  logic                     center_r;
  logic [7:0]               k_r, count_r;
  logic signed [PW-1:0]     prr_r, pii_r, pri_r;
  logic                     out_valid_r;
  met_pkg::out_word_t       out_word_r;

  logic                     big, esc, finish, out_free;
  logic [PW-1:0]            mag2;
  logic signed [ZW-1:0]     rr, ii, ri, zre_new, zim_new;

  // products of z_k give both the escape test of z_k and z_(k+1)
  always_comb begin
    big  = (zre_r > TWO_FX) || (zre_r < -TWO_FX) ||
           (zim_r > TWO_FX) || (zim_r < -TWO_FX);
    mag2 = $unsigned(prr_r) + $unsigned(pii_r);
    esc  = (k_r != '0) && (big || (mag2 > FOUR_SQ));
    finish = esc || (k_r == max_iter);
    rr = ZW'(prr_r >>> FRACTION_BITS);
    ii = ZW'(pii_r >>> FRACTION_BITS);
    ri = ZW'(pri_r >>> (FRACTION_BITS - 1));
    zre_new = rr - ii + cre_r;
    zim_new = ri + cim_r;
  end

  assign out_free  = !out_valid_r || out_pop;
  assign q_pop     = (state_r == B_IDLE) && !q_empty;
  assign out_empty = !out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (!q_empty) state_nxt = B_MUL;
      B_MUL:   state_nxt = B_ADD;
      B_ADD:   state_nxt = finish ? B_FIN : B_MUL;
      B_FIN:   if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          cre_r    <= $signed(c_re);
          cim_r    <= $signed(c_im);
          center_r <= center;
          zre_r    <= '0;
          zim_r    <= '0;
          k_r      <= '0;
        end
      end
      B_MUL: begin
        prr_r <= zre_r * zre_r;
        pii_r <= zim_r * zim_r;
        pri_r <= zre_r * zim_r;
      end
      B_ADD: begin
        if (finish) begin
          count_r <= esc ? k_r - 1'b1 : k_r;
        end else begin
          zre_r <= zre_new;
          zim_r <= zim_new;
          k_r   <= k_r + 1'b1;
        end
      end
      B_FIN: begin
        if (out_free) begin
          out_word_r.iteration_count <= count_r;
          if (center_r) begin
            out_word_r.write_pixel <= 1'b1;
            out_word_r.pixel_color <= met_pkg::COLOR_CENTER;
          end else if (count_r < light_thr) begin
            out_word_r.write_pixel <= 1'b1;
            out_word_r.pixel_color <= met_pkg::COLOR_LIGHT;
          end else begin
            out_word_r.write_pixel <= 1'b0;
            out_word_r.pixel_color <= met_pkg::COLOR_NONE;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
